FILE: rtl/sstf_disk_scheduler_top_assert.svh
// Assertion macros for the scheduler top level.
`ifndef SSTF_DISK_SCHEDULER_TOP_ASSERT_SVH
`define SSTF_DISK_SCHEDULER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sstf_pkg.sv
package sstf_pkg;

	localparam int unsigned SUM_W   = 32;
	localparam int unsigned CNT_O_W = 8;
	localparam int unsigned TRK_I_W = 16;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_WAIT,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr;
		logic vld;
	} pick_ctl_t;

endpackage

FILE: rtl/sstf_ram.sv
module sstf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/sstf_pick.sv
module sstf_pick #(
	parameter int unsigned AW = 7,
	parameter int unsigned TW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sstf_pkg::pick_ctl_t ctl,
	input  logic [AW-1:0]      rd_idx,
	input  logic [TW:0]        rd_data,
	input  logic [TW-1:0]      head,
	output logic               found,
	output logic [AW-1:0]      best_idx,
	output logic [TW-1:0]      best_track,
	output logic [TW-1:0]      best_gap
);
	import sstf_pkg::*;

	logic          found_q;
	logic [AW-1:0] best_idx_q;
	logic [TW-1:0] best_track_q;
	logic [TW-1:0] best_gap_q;
	logic [TW-1:0] trk;
	logic [TW-1:0] gap;
	logic          take;

	assign trk  = rd_data[TW-1:0];
	assign gap  = (trk >= head) ? (trk - head) : (head - trk);
	assign take = ctl.vld && !rd_data[TW] && (!found_q || (gap < best_gap_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= rd_idx;
			best_track_q <= trk;
			best_gap_q   <= gap;
		end
	end

	assign found      = found_q;
	assign best_idx   = best_idx_q;
	assign best_track = best_track_q;
	assign best_gap   = best_gap_q;

endmodule

FILE: rtl/sstf_disk_scheduler_top.sv
// Requests are taken only while loading, where in_stall is low; the request store is a single RAM.
// Scheduling runs one selection per request: each selection scans the RAM once
// (one read per cycle, read data registered in the RAM), waits for the last read and then writes back a served flag.
// The result is loaded into an output register from the finish state once the output is free, and is held there.
// Reset clears the control state, counters, head, running sum and start_head register.
module sstf_disk_scheduler_top #(
	parameter int unsigned MAX_REQ    = 128,
	parameter int unsigned TRACK_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start_head_we,
	input  logic [sstf_pkg::TRK_I_W-1:0]   start_head,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sstf_pkg::TRK_I_W-1:0]   request_track,
	input  logic                           last_request,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sstf_pkg::SUM_W-1:0]     total_movement,
	output logic [sstf_pkg::CNT_O_W-1:0]   request_count,
	output logic                           overflow
);
	import sstf_pkg::*;

	localparam int unsigned AW = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;
	localparam int unsigned CW = $clog2(MAX_REQ + 1);
	localparam int unsigned XW = CW + CNT_O_W;

	state_t state_q, state_d;

	logic [TRK_I_W-1:0]    start_head_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         sel_cnt_q;
	logic [AW-1:0]         scan_idx_q;
	logic                  dropped_q;
	logic [TRACK_BITS-1:0] head_q;
	logic [SUM_W-1:0]      sum_q;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_idx_s1;

	logic                  out_valid_q;
	logic [SUM_W-1:0]      total_q;
	logic [CNT_O_W-1:0]    rcount_q;
	logic                  ovf_q;

	logic                  in_xfer;
	logic                  room;
	logic [CW-1:0]         count_nxt;
	logic                  scan_last;
	logic                  sel_last;
	logic                  out_free;
	logic [SUM_W:0]        acc;
	logic [SUM_W-1:0]      sum_sat;
	logic [XW-1:0]         cnt_ext;
	logic [TRACK_BITS-1:0] track_in;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [TRACK_BITS:0]   ram_wdata;
	logic                  ram_re;
	logic [TRACK_BITS:0]   ram_rdata;

	pick_ctl_t             pick_ctl;
	logic                  found;
	logic [AW-1:0]         best_idx;
	logic [TRACK_BITS-1:0] best_track;
	logic [TRACK_BITS-1:0] best_gap;

	assign in_xfer   = in_valid && !in_stall;
	assign room      = count_q < CW'(MAX_REQ);
	assign count_nxt = room ? CW'(count_q + 1'b1) : count_q;
	assign track_in  = TRACK_BITS'(request_track);
	assign scan_last = CW'(scan_idx_q) == CW'(count_q - 1'b1);
	assign sel_last  = CW'(sel_cnt_q + 1'b1) >= count_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign acc       = {1'b0, sum_q} + (SUM_W + 1)'(best_gap);
	assign sum_sat   = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
	assign cnt_ext   = XW'(count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_xfer && last_request) begin
					state_d = (count_nxt == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: state_d = ST_UPDATE;
			ST_UPDATE: state_d = sel_last ? ST_FINISH : ST_SCAN;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		ram_we       = 1'b0;
		ram_waddr    = best_idx;
		ram_wdata    = {1'b1, best_track};
		ram_re       = 1'b0;
		pick_ctl.clr = 1'b0;
		pick_ctl.vld = rd_vld_s1;
		unique case (state_q)
			ST_LOAD: begin
				in_stall     = 1'b0;
				ram_we       = in_xfer && room;
				ram_waddr    = count_q[AW-1:0];
				ram_wdata    = {1'b0, track_in};
				pick_ctl.clr = in_xfer && last_request;
			end
			ST_SCAN: ram_re = 1'b1;
			ST_WAIT: ;
			ST_UPDATE: begin
				ram_we       = 1'b1;
				pick_ctl.clr = 1'b1;
			end
			ST_FINISH: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			start_head_q <= '0;
			count_q      <= '0;
			sel_cnt_q    <= '0;
			scan_idx_q   <= '0;
			dropped_q    <= 1'b0;
			head_q       <= '0;
			sum_q        <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			if (start_head_we) begin
				start_head_q <= start_head;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						count_q   <= count_nxt;
						dropped_q <= dropped_q || !room;
						if (last_request) begin
							head_q     <= TRACK_BITS'(start_head_q);
							sum_q      <= '0;
							sel_cnt_q  <= '0;
							scan_idx_q <= '0;
						end
					end
				end
				ST_SCAN: scan_idx_q <= scan_last ? '0 : AW'(scan_idx_q + 1'b1);
				ST_WAIT: ;
				ST_UPDATE: begin
					head_q    <= best_track;
					sum_q     <= sum_sat;
					sel_cnt_q <= CW'(sel_cnt_q + 1'b1);
				end
				ST_FINISH: begin
					if (out_free) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
						sum_q     <= '0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		if (state_q == ST_FINISH && out_free) begin
			total_q  <= sum_q;
			rcount_q <= (cnt_ext > XW'(255)) ? {CNT_O_W{1'b1}} : cnt_ext[CNT_O_W-1:0];
			ovf_q    <= dropped_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign total_movement = total_q;
	assign request_count  = rcount_q;
	assign overflow       = ovf_q;

	sstf_ram #(
		.WIDTH(TRACK_BITS + 1),
		.DEPTH(MAX_REQ)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(scan_idx_q),
		.rdata(ram_rdata)
	);

	sstf_pick #(
		.AW(AW),
		.TW(TRACK_BITS)
	) u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pick_ctl),
		.rd_idx    (rd_idx_s1),
		.rd_data   (ram_rdata),
		.head      (head_q),
		.found     (found),
		.best_idx  (best_idx),
		.best_track(best_track),
		.best_gap  (best_gap)
	);

`include "sstf_disk_scheduler_top_assert.svh"

	`SSTF_ASSERT_NOW(a_in_only_load, in_xfer, state_q == ST_LOAD, "input transfer outside load")
	`SSTF_ASSERT_NOW(a_update_found, state_q == ST_UPDATE, found, "no request selected")
	`SSTF_ASSERT_NOW(a_sel_bound, state_q == ST_SCAN, sel_cnt_q < count_q, "selection overrun")
	`SSTF_ASSERT_NEXT(a_out_after_finish, state_q == ST_FINISH && out_free, out_valid,
		"result not presented")

endmodule

FILE: tb/sstf_disk_scheduler_top_test.sv
`timescale 1ns / 100ps

module sstf_disk_scheduler_top_test;

	localparam int unsigned MAX_REQ        = 128;
	localparam int unsigned TRACK_BITS     = 16;
	localparam int unsigned TRK_W          = sstf_pkg::TRK_I_W;
	localparam int unsigned RANDOM_ITEMS   = 1850;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned WATCHDOG_LIMIT = 60000;
	localparam int unsigned DIRECTED_N     = 21;

	typedef struct packed {
		logic [sstf_pkg::SUM_W-1:0]   total;
		logic [sstf_pkg::CNT_O_W-1:0] count;
		logic                         ovf;
	} batch_summary_t;

	typedef struct packed {
		logic             set_head;
		logic [TRK_W-1:0] head;
		logic [TRK_W-1:0] track;
		logic             last;
		logic [7:0]       reps;
		logic             typed;
		batch_summary_t   summary;
	} seek_row_t;

	// Rows that set the head wait for the scheduler to go idle first. A row with
	// several repetitions marks only its final transfer as the last of the batch.
	localparam seek_row_t DIRECTED_ROWS [DIRECTED_N] = '{
		'{1'b1, 16'h0000, 16'h0000, 1'b1, 8'd1,   1'b1, '{32'd0,     8'd1,   1'b0}},
		'{1'b0, 16'h0000, 16'hFFFF, 1'b1, 8'd1,   1'b1, '{32'd65535, 8'd1,   1'b0}},
		'{1'b1, 16'hFFFF, 16'h0000, 1'b1, 8'd1,   1'b1, '{32'd65535, 8'd1,   1'b0}},
		'{1'b0, 16'h0000, 16'hFFFF, 1'b1, 8'd1,   1'b1, '{32'd0,     8'd1,   1'b0}},
		'{1'b1, 16'd100,  16'd110,  1'b0, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b0, 16'h0000, 16'd90,   1'b1, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b1, 16'h8000, 16'h0000, 1'b0, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b0, 16'h0000, 16'hFFFF, 1'b0, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b0, 16'h0000, 16'h8000, 1'b0, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b0, 16'h0000, 16'h7FFF, 1'b0, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b0, 16'h0000, 16'h8001, 1'b1, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b1, 16'h0000, 16'h1234, 1'b1, 8'd130, 1'b1, '{32'h1234,  8'd128, 1'b1}},
		'{1'b0, 16'h0000, 16'h0042, 1'b1, 8'd1,   1'b1, '{32'h0042,  8'd1,   1'b0}},
		'{1'b0, 16'h0000, 16'h0007, 1'b1, 8'd128, 1'b1, '{32'd7,     8'd128, 1'b0}},
		'{1'b1, 16'hAAAA, 16'h5555, 1'b0, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b0, 16'h0000, 16'hAAAA, 1'b0, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b0, 16'h0000, 16'hFFFF, 1'b0, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b0, 16'h0000, 16'h0000, 1'b1, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b1, 16'h0000, 16'h0300, 1'b0, 8'd129, 1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b0, 16'h0000, 16'h0100, 1'b1, 8'd1,   1'b0, '{32'd0,     8'd0,   1'b0}},
		'{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 8'd1,   1'b1, '{32'd0,     8'd1,   1'b0}}
	};

	logic                         clk;
	logic                         arst_n;
	logic                         start_head_we;
	logic [TRK_W-1:0]             start_head;
	logic                         in_valid;
	logic                         in_stall;
	logic [TRK_W-1:0]             request_track;
	logic                         last_request;
	logic                         out_valid;
	logic                         out_stall;
	logic [sstf_pkg::SUM_W-1:0]   total_movement;
	logic [sstf_pkg::CNT_O_W-1:0] request_count;
	logic                         overflow;

	logic [TRK_W-1:0] track_store [MAX_REQ];
	int unsigned      stored_n;
	logic             dropped;
	logic [TRK_W-1:0] cfg_head;

	batch_summary_t due_summaries [$];
	batch_summary_t oldest_due;
	int unsigned    error_count;
	int unsigned    idle_cycles;
	int unsigned    stall_left;
	bit             quiet;

	sstf_disk_scheduler_top #(
		.MAX_REQ    (MAX_REQ),
		.TRACK_BITS (TRACK_BITS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start_head_we  (start_head_we),
		.start_head     (start_head),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.request_track  (request_track),
		.last_request   (last_request),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.total_movement (total_movement),
		.request_count  (request_count),
		.overflow       (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit account_request(input logic [TRK_W-1:0] trk, input logic lst,
			output batch_summary_t res);
		logic             served [MAX_REQ];
		logic [TRK_W-1:0] pos;
		longint unsigned  sum;
		int unsigned      best_gap;
		int unsigned      gap;
		int               pick;
		int               k;
		int               j;
		res = '0;
		if (stored_n < MAX_REQ) begin
			track_store[stored_n] = trk;
			stored_n++;
		end else begin
			dropped = 1'b1;
		end
		if (!lst)
			return 1'b0;
		pos = cfg_head;
		sum = 0;
		best_gap = 0;
		for (k = 0; k < MAX_REQ; k++)
			served[k] = 1'b0;
		for (k = 0; k < stored_n; k++) begin
			pick = -1;
			for (j = 0; j < stored_n; j++) begin
				if (!served[j]) begin
					gap = (track_store[j] >= pos) ? track_store[j] - pos : pos - track_store[j];
					if (pick < 0 || gap < best_gap) begin
						best_gap = gap;
						pick = j;
					end
				end
			end
			sum += best_gap;
			if (sum > 64'hFFFF_FFFF)
				sum = 64'hFFFF_FFFF;
			pos = track_store[pick];
			served[pick] = 1'b1;
		end
		res.total = sum[31:0];
		res.count = (stored_n > 255) ? 8'd255 : stored_n[7:0];
		res.ovf = dropped;
		stored_n = 0;
		dropped = 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned pick_gap(input int unsigned long_lo, input int unsigned long_hi);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(long_lo, long_hi);
	endfunction

	task automatic send_request(input logic [TRK_W-1:0] trk, input logic lst, input logic typed,
			input batch_summary_t typed_sum);
		int unsigned    gap;
		batch_summary_t predicted;
		gap = pick_gap(20, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		request_track <= trk;
		last_request <= lst;
		do
			@(posedge clk);
		while (in_stall);
		if (account_request(trk, lst, predicted))
			due_summaries.push_back(typed ? typed_sum : predicted);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (due_summaries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_start_head(input logic [TRK_W-1:0] v);
		start_head_we <= 1'b1;
		start_head <= v;
		@(negedge clk);
		start_head_we <= 1'b0;
		cfg_head = v;
	endtask

	task automatic run_batch(inout int unsigned sent);
		int unsigned      size;
		int unsigned      mode;
		int unsigned      r;
		int unsigned      i;
		logic [TRK_W-1:0] base;
		logic [TRK_W-1:0] trk;
		r = $urandom_range(0, 99);
		if (r < 85)
			size = $urandom_range(1, 10);
		else if (r < 98)
			size = $urandom_range(11, 40);
		else
			size = $urandom_range(MAX_REQ - 3, MAX_REQ + 12);
		mode = $urandom_range(0, 3);
		base = TRK_W'($urandom);
		for (i = 0; i < size; i++) begin
			case (mode)
				0: begin
					trk = TRK_W'($urandom);
				end
				1: begin
					trk = TRK_W'(base + $urandom_range(0, 15) - 16'd8);
				end
				2: begin
					trk = TRK_W'($urandom_range(0, 1) ? 16'hFFFF - $urandom_range(0, 3)
						: $urandom_range(0, 3));
				end
				default: begin
					trk = TRK_W'($urandom_range(0, 1) ? cfg_head + $urandom_range(0, 4)
						: cfg_head - $urandom_range(0, 4));
				end
			endcase
			send_request(trk, i == size - 1, 1'b0, '0);
			sent++;
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n || quiet) begin
			stall_left = 0;
		end else if (stall_left == 0) begin
			stall_left = pick_gap(30, 80);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_summaries.size() == 0) begin
				$display("%0t: result with none due: total %0d count %0d overflow %0b",
					$time, total_movement, request_count, overflow);
				error_count++;
			end else begin
				oldest_due = due_summaries.pop_front();
				if (total_movement !== oldest_due.total) begin
					$display("%0t: total_movement expected %0d, actual %0d",
						$time, oldest_due.total, total_movement);
					error_count++;
				end
				if (request_count !== oldest_due.count) begin
					$display("%0t: request_count expected %0d, actual %0d",
						$time, oldest_due.count, request_count);
					error_count++;
				end
				if (overflow !== oldest_due.ovf) begin
					$display("%0t: overflow expected %0b, actual %0b",
						$time, oldest_due.ovf, overflow);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		seek_row_t   row;
		int unsigned row_i;
		int unsigned rep;
		int unsigned sent;
		int unsigned batches;
		int unsigned r;
		arst_n = 1'b0;
		start_head_we = 1'b0;
		start_head = '0;
		in_valid = 1'b0;
		request_track = '0;
		last_request = 1'b0;
		out_stall = 1'b0;
		stored_n = 0;
		dropped = 1'b0;
		cfg_head = '0;
		error_count = 0;
		idle_cycles = 0;
		stall_left = 0;
		quiet = 1'b0;
		sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row_i = 0; row_i < DIRECTED_N; row_i++) begin
			row = DIRECTED_ROWS[row_i];
			if (row.set_head) begin
				drain_results();
				load_start_head(row.head);
			end
			for (rep = 0; rep < row.reps; rep++) begin
				send_request(row.track, row.last && rep == row.reps - 1, row.typed, row.summary);
				sent++;
			end
		end

		while (sent < RANDOM_ITEMS) begin
			drain_results();
			r = $urandom_range(0, 9);
			if (r == 0)
				load_start_head('0);
			else if (r == 1)
				load_start_head('1);
			else
				load_start_head(TRK_W'($urandom));
			quiet = ($urandom_range(0, 4) == 0);
			batches = $urandom_range(1, 6);
			repeat (batches) run_batch(sent);
		end
		quiet = 1'b0;

		drain_results();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
